// File: rtl/wpss_pkg.sv
// Shared types and constants for the weighted priority service scheduler.
package wpss_pkg;

    localparam int CNT_W        = 16;
    localparam int WGT_W        = 16;
    localparam int BACKLOG_W    = 38;
    localparam int PROD_W       = CNT_W + WGT_W;
    localparam int CAP_DEFAULT  = 64;
    localparam int CAP_MAX      = 1024;
    // Slot index width that covers the largest supported table.
    localparam int IDX_W        = $clog2(CAP_MAX);

    localparam logic FUNC_ARRIVAL = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    typedef struct packed {
        logic             func;
        logic [CNT_W-1:0] lesson_count;
        logic [WGT_W-1:0] job_weight;
    } t_in_word;

    typedef struct packed {
        logic [BACKLOG_W-1:0] backlog_sum;
        logic                 served;
        logic [WGT_W-1:0]     served_weight;
        logic                 dropped;
    } t_out_word;

    // Search packet that walks down the row of slot cells.
    typedef struct packed {
        logic             vld;
        logic             has_best;
        logic [IDX_W-1:0] best_pos;
        logic [WGT_W-1:0] best_wgt;
        logic             has_free;
        logic [IDX_W-1:0] free_pos;
    } t_scan_pkt;

    // Update broadcast to all cells when an item commits.
    typedef struct packed {
        logic             wr;
        logic             dec;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] count;
        logic [WGT_W-1:0] weight;
    } t_slot_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

endpackage

// File: rtl/wpss_cell.sv
// One job slot of the scheduler table plus its stage of the search chain.
module wpss_cell #(
    parameter int SLOT_IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wpss_pkg::t_scan_pkt i_pkt,
    input  wpss_pkg::t_slot_cmd i_cmd,
    output wpss_pkg::t_scan_pkt o_pkt
);
    import wpss_pkg::*;

    logic             r_valid;
    logic [CNT_W-1:0] r_count;
    logic [WGT_W-1:0] r_weight;
    t_scan_pkt        r_pkt;
    t_scan_pkt        n_pkt;
    logic             w_hit;

    assign w_hit = (i_cmd.idx == IDX_W'(SLOT_IDX));

    // A pending slot beats the best so far only with a strictly larger
    // weight, so the lowest slot keeps a tie.
    always_comb begin
        n_pkt = i_pkt;
        if (r_valid && (!i_pkt.has_best || (r_weight > i_pkt.best_wgt))) begin
            n_pkt.has_best = 1'b1;
            n_pkt.best_pos = IDX_W'(SLOT_IDX);
            n_pkt.best_wgt = r_weight;
        end
        if (!r_valid && !i_pkt.has_free) begin
            n_pkt.has_free = 1'b1;
            n_pkt.free_pos = IDX_W'(SLOT_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt <= '0;
        end else begin
            r_pkt <= n_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_hit && i_cmd.wr) begin
            r_valid <= 1'b1;
        end else if (w_hit && i_cmd.dec && (r_count == CNT_W'(1))) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hit && i_cmd.wr) begin
            r_count  <= i_cmd.count;
            r_weight <= i_cmd.weight;
        end else if (w_hit && i_cmd.dec) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    assign o_pkt = r_pkt;

endmodule

// File: rtl/weighted_priority_service_scheduler_top.sv
// Top level of the weighted priority service scheduler.
//
// The block keeps a table of pending jobs, each with a remaining service
// count and a weight, and a running weighted backlog. An input word with
// func set to arrival stores a job in the lowest free slot; a word with func
// set to tick serves the heaviest pending job, lowest slot on a tie.
// Every input word produces exactly one output word carrying the backlog
// after the step and the served, served_weight and dropped flags.
// Both channels use valid and stall; a word moves on a rising edge where
// valid is high and stall is low.
// Each slot is a cell in a row, and a search packet walks one cell per
// cycle to find the free slot and the heaviest slot. An item takes one hop
// per cell, the first at the accepting edge itself; the search result is
// then captured in a register and the item commits. The next word is
// accepted in the cycle after the commit, so a new item is taken only once
// the last one has committed. The result sits in an output register, so a
// stalled receiver does not block the next item's search; only the commit
// waits until the output register is free. Synchronous active low reset
// empties the table and clears the backlog; no clearing pass is needed.
module weighted_priority_service_scheduler_top #(
    parameter int CAPACITY = wpss_pkg::CAP_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wpss_pkg::t_in_word i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wpss_pkg::t_out_word o_out_word
);
    import wpss_pkg::*;

    t_state               r_state;
    t_state               n_state;
    t_in_word             r_item;
    logic [PROD_W-1:0]    r_prod;
    t_scan_pkt            r_res;
    logic [BACKLOG_W-1:0] r_backlog;
    logic [BACKLOG_W-1:0] n_backlog;
    logic                 r_out_vld;
    t_out_word            r_out;
    t_out_word            n_out;
    t_slot_cmd            w_cmd;
    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_commit;
    t_scan_pkt            w_pkt [CAPACITY+1];
    logic [CAPACITY-1:0]  w_pkt_vld;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_commit   = (r_state == ST_COMMIT) && w_out_free;

    // A fresh, empty search packet enters the first cell when a word is taken.
    assign w_pkt[0] = '{vld: w_in_acc, default: '0};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        wpss_cell #(
            .SLOT_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pkt   (w_pkt[g]),
            .i_cmd   (w_cmd),
            .o_pkt   (w_pkt[g+1])
        );
        assign w_pkt_vld[g] = w_pkt[g+1].vld;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_pkt[CAPACITY].vld) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commit: the slot update, the new backlog and the output word.
    always_comb begin
        w_cmd     = '0;
        n_backlog = r_backlog;
        n_out     = '0;
        if (w_commit) begin
            if (r_item.func == FUNC_ARRIVAL) begin
                // A job with no service units is ignored outright.
                if (r_item.lesson_count != '0) begin
                    if (r_res.has_free) begin
                        w_cmd.wr     = 1'b1;
                        w_cmd.idx    = r_res.free_pos;
                        w_cmd.count  = r_item.lesson_count;
                        w_cmd.weight = r_item.job_weight;
                        n_backlog    = r_backlog + BACKLOG_W'(r_prod);
                    end else begin
                        n_out.dropped = 1'b1;
                    end
                end
            end else if (r_res.has_best) begin
                w_cmd.dec           = 1'b1;
                w_cmd.idx           = r_res.best_pos;
                n_out.served        = 1'b1;
                n_out.served_weight = r_res.best_wgt;
                n_backlog           = r_backlog - BACKLOG_W'(r_res.best_wgt);
            end
        end
        n_out.backlog_sum = n_backlog;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_backlog <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_backlog <= n_backlog;
            if (w_commit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // The product is formed during the search and is settled by commit time.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item <= i_in_word;
        end
        r_prod <= r_item.lesson_count * r_item.job_weight;
        if (w_pkt[CAPACITY].vld) begin
            r_res <= w_pkt[CAPACITY];
        end
        if (w_commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // At most one search packet is ever in flight along the row.
    a_one_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_pkt_vld))
        else $error("more than one search packet in the cell row");

    // The backlog moves only when an item commits.
    a_backlog_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_commit |=> $stable(r_backlog))
        else $error("backlog changed outside a commit");

    // A word never reports both a service and a refused arrival.
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out.served && r_out.dropped))
        else $error("served and dropped both set");

    // A word without a service carries zero served weight.
    a_weight_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.served) |-> (r_out.served_weight == '0))
        else $error("served_weight set without a service");

endmodule

// File: tb/tb.sv
// Testbench for the weighted priority service scheduler.
`timescale 1ns / 100ps

module tb;
    import wpss_pkg::*;

    // The block is built at its default table size.
    localparam int TABLE_SLOTS = CAP_DEFAULT;
    localparam int SETTLE_CYCLES = TABLE_SLOTS + 8;
    localparam int DAILY_WORDS = 340;

    // Clock, reset and the two channels. Every input has a known value from time zero.
    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    // Our own copy of the job table and the backlog. It is advanced once per
    // accepted word, and each step leaves one expected result word behind.
    logic [CNT_W-1:0]     job_left [TABLE_SLOTS];
    logic [WGT_W-1:0]     job_prio [TABLE_SLOTS];
    logic                 job_live [TABLE_SLOTS];
    logic [BACKLOG_W-1:0] backlog_now = '0;
    t_out_word            pending_results[$];

    // Run bookkeeping.
    int  mismatch_count = 0;
    int  results_checked = 0;
    int  arrivals_sent = 0;
    int  ticks_sent = 0;
    int  drops_seen = 0;
    int  serves_seen = 0;
    int  ties_seen = 0;
    bit  calm = 1'b0;

    weighted_priority_service_scheduler_top #(
        .CAPACITY(TABLE_SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    always #6 i_clk = ~i_clk;

    // Idle stretches: mostly a few cycles, now and then long enough to land
    // anywhere in the block's search of the table.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 150);
    endfunction

    function automatic int live_slots();
        int n;
        int i;
        n = 0;
        for (i = 0; i < TABLE_SLOTS; i++) begin
            if (job_live[i]) begin
                n++;
            end
        end
        return n;
    endfunction

    // Advance the job table by one word and return the result word that the
    // block must answer with. An arrival takes the lowest free slot; a tick
    // serves the heaviest live job, and the lowest slot wins a tie.
    function automatic t_out_word schedule_step(t_in_word w);
        t_out_word        r;
        logic [PROD_W-1:0] units;
        int               pick;
        int               i;
        r = '0;
        pick = -1;
        if (w.func == FUNC_ARRIVAL) begin
            if (w.lesson_count != '0) begin
                for (i = TABLE_SLOTS - 1; i >= 0; i--) begin
                    if (!job_live[i]) begin
                        pick = i;
                    end
                end
                if (pick < 0) begin
                    r.dropped = 1'b1;
                    drops_seen++;
                end else begin
                    job_left[pick] = w.lesson_count;
                    job_prio[pick] = w.job_weight;
                    job_live[pick] = 1'b1;
                    units = w.lesson_count * w.job_weight;
                    backlog_now = backlog_now + units;
                end
            end
        end else begin
            for (i = 0; i < TABLE_SLOTS; i++) begin
                if (job_live[i]) begin
                    if (pick < 0 || job_prio[i] > job_prio[pick]) begin
                        pick = i;
                    end else if (job_prio[i] == job_prio[pick]) begin
                        ties_seen++;
                    end
                end
            end
            if (pick >= 0) begin
                r.served = 1'b1;
                r.served_weight = job_prio[pick];
                backlog_now = backlog_now - job_prio[pick];
                job_left[pick] = job_left[pick] - 1'b1;
                if (job_left[pick] == '0) begin
                    job_live[pick] = 1'b0;
                end
                serves_seen++;
            end
        end
        r.backlog_sum = backlog_now;
        return r;
    endfunction

    // Send one word. The word is presented at a rising edge and held until
    // the block stops stalling; stall is sampled at the falling edge, where it
    // already shows what the block will see at the next rising edge. The
    // expected result is queued at the edge that accepts the word.
    task automatic send_word(input t_in_word w);
        int gap;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(negedge i_clk);
        while (o_in_stall) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        pending_results.push_back(schedule_step(w));
        if (w.func == FUNC_ARRIVAL) begin
            arrivals_sent++;
        end else begin
            ticks_sent++;
        end
    endtask

    // Stop sending and hold off until every expected result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() > 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic t_in_word make_word(logic fn, int cnt, int wgt);
        t_in_word w;
        w.func = fn;
        w.lesson_count = CNT_W'(cnt);
        w.job_weight = WGT_W'(wgt);
        return w;
    endfunction

    // A tick carries count and weight fields that the block must ignore.
    function automatic t_in_word make_tick();
        return make_word(FUNC_TICK, $urandom_range(0, 65535), $urandom_range(0, 65535));
    endfunction

    // Daily arrivals are short jobs. Weights come partly from a few fixed
    // values, so that equal weights and ties between slots are common.
    function automatic t_in_word make_arrival();
        int cnt;
        int wgt;
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            cnt = 1;
        end else if (r < 85) begin
            cnt = $urandom_range(2, 4);
        end else begin
            cnt = $urandom_range(5, 30);
        end
        case ($urandom_range(0, 9))
            0: begin
                wgt = 0;
            end
            1: begin
                wgt = 'hFFFF;
            end
            2: begin
                wgt = 'h8000;
            end
            3: begin
                wgt = 1;
            end
            default: begin
                wgt = $urandom_range(0, 65535);
            end
        endcase
        return make_word(FUNC_ARRIVAL, cnt, wgt);
    endfunction

    // Ticks on an empty table must serve nothing and leave the backlog at zero.
    task automatic test_empty_table();
        send_word(make_word(FUNC_TICK, 'hFFFF, 'hFFFF));
        send_word(make_word(FUNC_TICK, 0, 0));
        drain_results();
    endtask

    // Hand-picked cases: a zero count arrival, the field extremes, equal
    // weights in several slots and reuse of a freed slot.
    task automatic test_directed_cases();
        calm = 1'b1;
        send_word(make_word(FUNC_ARRIVAL, 0, 'hFFFF));
        // A very long job of weight zero: lowest priority, it stays pending.
        send_word(make_word(FUNC_ARRIVAL, 'hFFFF, 0));
        send_word(make_word(FUNC_ARRIVAL, 1, 'hFFFF));
        send_word(make_word(FUNC_ARRIVAL, 3, 'h0100));
        send_word(make_word(FUNC_ARRIVAL, 1, 'h0100));
        send_word(make_tick());
        // This job lands in the slot just freed, below the two equal weights.
        send_word(make_word(FUNC_ARRIVAL, 2, 'h0100));
        repeat (3) send_word(make_tick());
        send_word(make_word(FUNC_ARRIVAL, 1, 0));
        repeat (5) send_word(make_tick());
        drain_results();
        calm = 1'b0;
    endtask

    // The normal use: each day brings a few arrivals and then one tick.
    // Arrivals pause while the table is busy so that it keeps emptying.
    // About one step in ten is noise: a stray tick or a zero count arrival.
    task automatic test_daily_schedule(input int n_words);
        int sent;
        int n_arr;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_word(make_tick());
                end else begin
                    send_word(make_word(FUNC_ARRIVAL, 0, $urandom_range(0, 65535)));
                end
                sent++;
            end else begin
                n_arr = (live_slots() > 14) ? 0 : $urandom_range(0, 3);
                repeat (n_arr) begin
                    send_word(make_arrival());
                    sent++;
                end
                send_word(make_tick());
                sent++;
            end
            if ($urandom_range(0, 29) == 0) begin
                calm = !calm;
            end
            if ($urandom_range(0, 59) == 0) begin
                drain_results();
            end
        end
        calm = 1'b0;
        drain_results();
    endtask

    // Fill every slot, mostly with long heavy jobs so that the backlog
    // reaches its top bits, then push arrivals at the full table. A few
    // single-unit jobs of the top weight let ticks free slots again.
    task automatic test_full_table();
        int k;
        k = 0;
        while (live_slots() < TABLE_SLOTS) begin
            if (k % 8 == 7) begin
                send_word(make_word(FUNC_ARRIVAL, 1, 'hFFFF));
            end else if (k % 4 == 2) begin
                send_word(make_word(FUNC_ARRIVAL, $urandom_range(1, 65535),
                                    $urandom_range(0, 65535)));
            end else begin
                send_word(make_word(FUNC_ARRIVAL, 'hFFFF, $urandom_range(60000, 65535)));
            end
            k++;
        end
        repeat (3) send_word(make_arrival());
        send_word(make_word(FUNC_ARRIVAL, 0, 'h1234));
        repeat (4) begin
            repeat (2) send_word(make_tick());
            repeat (3) send_word(make_arrival());
        end
        drain_results();
    endtask

    // Compare one field of a result word; the first mismatches are shown.
    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("result %0d: %s expected %0h, got %0h",
                         results_checked, name, want, got);
            end
        end
    endtask

    // Result checking. A word moves at the rising edge after a falling edge
    // where valid is high and stall low, so it is checked at that falling edge.
    always @(negedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("result %0d arrived with nothing expected", results_checked);
                end
            end else begin
                want = pending_results.pop_front();
                compare_field("backlog_sum", 64'(want.backlog_sum),
                              64'(o_out_word.backlog_sum));
                compare_field("served", 64'(want.served), 64'(o_out_word.served));
                compare_field("served_weight", 64'(want.served_weight),
                              64'(o_out_word.served_weight));
                compare_field("dropped", 64'(want.dropped), 64'(o_out_word.dropped));
            end
            results_checked++;
        end
    end

    // The receiver stalls in random stretches; while calm, no new stretch begins.
    int sink_left = 0;
    bit sink_hold = 1'b0;
    always @(posedge i_clk) begin
        if (sink_left > 0) begin
            sink_left = sink_left - 1;
        end else if (calm) begin
            sink_hold = 1'b0;
        end else begin
            sink_hold = ($urandom_range(0, 2) == 0);
            sink_left = sink_hold ? idle_len() : $urandom_range(0, 30);
        end
        i_out_stall <= sink_hold;
    end

    initial begin
        int i;
        for (i = 0; i < TABLE_SLOTS; i++) begin
            job_left[i] = '0;
            job_prio[i] = '0;
            job_live[i] = 1'b0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_directed_cases();
        test_daily_schedule(DAILY_WORDS);
        test_full_table();

        // Let any stray result word show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d arrivals and %0d ticks; %0d result words checked.",
                 arrivals_sent, ticks_sent, results_checked);
        $display("Jobs served %0d times, %0d equal-weight ties, %0d arrivals refused.",
                 serves_seen, ties_seen, drops_seen);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("weighted_priority_service_scheduler_top test passed");
        end else begin
            $display("weighted_priority_service_scheduler_top test failed");
        end
        $finish;
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    initial begin
        #(12_000_000);
        $display("weighted_priority_service_scheduler_top test failed");
        $finish;
    end

endmodule
